// ----- rtl/core/rvz_pkg.sv -----
// shared types, constants and the arctangent table for the z-axis vector rotator
`timescale 1ns / 1ps

package rvz_pkg;

    localparam int YAW_BITS   = 17;
    localparam int ANGLE_BITS = 18;
    localparam int MAG_BITS   = 14;
    localparam int THETA_BITS = 33;

    // angle units are 1/128 degree
    localparam logic signed [ANGLE_BITS-1:0] FULL_TURN    = 18'sd46080;
    localparam logic signed [ANGLE_BITS-1:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [ANGLE_BITS-1:0] QUARTER_TURN = 18'sd11520;

    // pi / (180 * 128) in q48, and the inverse cordic gain in q30
    localparam logic [35:0]        DEG_TO_RAD_Q48 = 36'd38380196137;
    localparam logic signed [30:0] GAIN_INV_Q30   = 31'sd652032874;

    typedef struct packed {
        logic valid;
        logic flip;
    } t_ctrl;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [29:0] atan_q30(input int unsigned idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd843314856;
            1:       v = 30'd497837829;
            2:       v = 30'd263043836;
            3:       v = 30'd133525158;
            4:       v = 30'd67021686;
            5:       v = 30'd33543515;
            6:       v = 30'd16775850;
            7:       v = 30'd8388437;
            8:       v = 30'd4194282;
            9:       v = 30'd2097149;
            10:      v = 30'd1048575;
            11:      v = 30'd524287;
            12:      v = 30'd262143;
            13:      v = 30'd131071;
            14:      v = 30'd65535;
            15:      v = 30'd32767;
            16:      v = 30'd16383;
            17:      v = 30'd8191;
            18:      v = 30'd4095;
            19:      v = 30'd2047;
            20:      v = 30'd1023;
            21:      v = 30'd511;
            22:      v = 30'd255;
            23:      v = 30'd127;
            24:      v = 30'd63;
            25:      v = 30'd31;
            26:      v = 30'd15;
            27:      v = 30'd7;
            28:      v = 30'd3;
            29:      v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/rvz_front.sv -----
// angle reduction, degree to radian conversion and gain pre-scaling
`timescale 1ns / 1ps

module rvz_front import rvz_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [COORD_BITS-1:0]  i_x,
    input  logic signed [COORD_BITS-1:0]  i_y,
    input  logic signed [COORD_BITS-1:0]  i_z,
    input  logic signed [YAW_BITS-1:0]    i_yaw,
    output t_ctrl                         o_ctrl,
    output logic signed [COORD_BITS+31:0] o_xs,
    output logic signed [COORD_BITS+31:0] o_ys,
    output logic signed [THETA_BITS-1:0]  o_theta,
    output logic signed [COORD_BITS-1:0]  o_z
);

    localparam int W = COORD_BITS + 32;

    // stage one
    logic signed [ANGLE_BITS-1:0] a_ext;
    logic signed [ANGLE_BITS-1:0] a_wrap;
    logic signed [ANGLE_BITS-1:0] a_fold;
    logic                         fold;
    logic signed [COORD_BITS+30:0] px;
    logic signed [COORD_BITS+30:0] py;

    t_ctrl                   r_ctl1, n_ctl1;
    logic [MAG_BITS-1:0]     r_mag, n_mag;
    logic                    r_neg;
    logic signed [W-1:0]     r_xs1, r_ys1;
    logic signed [COORD_BITS-1:0] r_z1;

    // stage two
    logic [49:0]             prod;
    logic [49:0]             rounded;
    logic [30:0]             theta_mag;
    t_ctrl                   r_ctl2;
    logic signed [THETA_BITS-1:0] r_theta, n_theta;
    logic signed [W-1:0]     r_xs2, r_ys2;
    logic signed [COORD_BITS-1:0] r_z2;

    always_comb begin
        a_ext = {i_yaw[YAW_BITS-1], i_yaw};
        if (a_ext >= HALF_TURN) begin
            a_wrap = a_ext - FULL_TURN;
        end else if (a_ext < -HALF_TURN) begin
            a_wrap = a_ext + FULL_TURN;
        end else begin
            a_wrap = a_ext;
        end
        // fold into [-90, +90] degrees, the result gets negated later
        fold = 1'b1;
        if (a_wrap > QUARTER_TURN) begin
            a_fold = a_wrap - HALF_TURN;
        end else if (a_wrap < -QUARTER_TURN) begin
            a_fold = a_wrap + HALF_TURN;
        end else begin
            a_fold = a_wrap;
            fold   = 1'b0;
        end
        n_mag = a_fold[ANGLE_BITS-1] ? MAG_BITS'(-a_fold) : a_fold[MAG_BITS-1:0];
        n_ctl1.valid = i_accept;
        n_ctl1.flip  = fold;
    end

    assign px = i_x * GAIN_INV_Q30;
    assign py = i_y * GAIN_INV_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= a_fold[ANGLE_BITS-1];
        r_xs1   <= {px[COORD_BITS+30], px};
        r_ys1   <= {py[COORD_BITS+30], py};
        r_z1    <= i_z;
        r_theta <= n_theta;
        r_xs2   <= r_xs1;
        r_ys2   <= r_ys1;
        r_z2    <= r_z1;
    end

    // radians in q30, rounded half away from zero on the magnitude
    assign prod      = {36'b0, r_mag} * {14'b0, DEG_TO_RAD_Q48};
    assign rounded   = prod + 50'd131072;
    assign theta_mag = rounded[48:18];

    always_comb begin
        if (r_neg) begin
            n_theta = -$signed({2'b00, theta_mag});
        end else begin
            n_theta = $signed({2'b00, theta_mag});
        end
    end

    assign o_ctrl  = r_ctl2;
    assign o_xs    = r_xs2;
    assign o_ys    = r_ys2;
    assign o_theta = r_theta;
    assign o_z     = r_z2;

endmodule

// ----- rtl/core/rvz_cell.sv -----
// one rotation-mode cordic micro-rotation with its pipeline register
`timescale 1ns / 1ps

module rvz_cell import rvz_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int STAGE      = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctrl                         i_ctrl,
    input  logic signed [COORD_BITS+31:0] i_xs,
    input  logic signed [COORD_BITS+31:0] i_ys,
    input  logic signed [THETA_BITS-1:0]  i_theta,
    input  logic signed [COORD_BITS-1:0]  i_z,
    output t_ctrl                         o_ctrl,
    output logic signed [COORD_BITS+31:0] o_xs,
    output logic signed [COORD_BITS+31:0] o_ys,
    output logic signed [THETA_BITS-1:0]  o_theta,
    output logic signed [COORD_BITS-1:0]  o_z
);

    localparam int W = COORD_BITS + 32;
    localparam logic signed [THETA_BITS-1:0] ATAN = $signed({3'b000, atan_q30(STAGE)});

    logic signed [W-1:0]          dx, dy;
    logic signed [W-1:0]          n_xs, n_ys;
    logic signed [THETA_BITS-1:0] n_theta;
    t_ctrl                        r_ctrl;
    logic signed [W-1:0]          r_xs, r_ys;
    logic signed [THETA_BITS-1:0] r_theta;
    logic signed [COORD_BITS-1:0] r_z;

    assign dx = i_ys >>> STAGE;
    assign dy = i_xs >>> STAGE;

    always_comb begin
        if (!i_theta[THETA_BITS-1]) begin
            n_xs    = i_xs - dx;
            n_ys    = i_ys + dy;
            n_theta = i_theta - ATAN;
        end else begin
            n_xs    = i_xs + dx;
            n_ys    = i_ys - dy;
            n_theta = i_theta + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs    <= n_xs;
        r_ys    <= n_ys;
        r_theta <= n_theta;
        r_z     <= i_z;
    end

    assign o_ctrl  = r_ctrl;
    assign o_xs    = r_xs;
    assign o_ys    = r_ys;
    assign o_theta = r_theta;
    assign o_z     = r_z;

endmodule

// ----- rtl/core/rvz_back.sv -----
// half-turn negation, rounding back to the input coordinate scale and saturation
`timescale 1ns / 1ps

module rvz_back import rvz_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctrl                         i_ctrl,
    input  logic signed [COORD_BITS+31:0] i_xs,
    input  logic signed [COORD_BITS+31:0] i_ys,
    input  logic signed [COORD_BITS-1:0]  i_z,
    output logic                          o_strobe,
    output logic signed [COORD_BITS-1:0]  o_x,
    output logic signed [COORD_BITS-1:0]  o_y,
    output logic signed [COORD_BITS-1:0]  o_z,
    output logic                          o_sat
);

    localparam int W  = COORD_BITS + 32;
    localparam int QW = COORD_BITS + 2;
    localparam logic [W-1:0] HALF_LSB = {{(W-30){1'b0}}, 30'h2000_0000};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                   r_vld_a;
    logic signed [W-1:0]    r_xn, r_yn;
    logic signed [COORD_BITS-1:0] r_za;

    logic signed [W-1:0]    sum_x, sum_y;
    logic signed [QW-1:0]   qx, qy;
    logic                   ovf_x, ovf_y;
    logic signed [COORD_BITS-1:0] n_x, n_y;

    logic                   r_strobe;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic                   r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld_a  <= i_ctrl.valid;
            r_strobe <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xn <= i_ctrl.flip ? -i_xs : i_xs;
        r_yn <= i_ctrl.flip ? -i_ys : i_ys;
        r_za <= i_z;
        r_x  <= n_x;
        r_y  <= n_y;
        r_z  <= r_za;
        r_sat <= ovf_x | ovf_y;
    end

    // round half up, drop the 30 extra fraction bits
    assign sum_x = r_xn + $signed(HALF_LSB);
    assign sum_y = r_yn + $signed(HALF_LSB);
    assign qx    = sum_x[W-1:30];
    assign qy    = sum_y[W-1:30];

    // top three bits must agree for the value to fit
    assign ovf_x = (qx[QW-1:COORD_BITS-1] != {3{qx[QW-1]}});
    assign ovf_y = (qy[QW-1:COORD_BITS-1] != {3{qy[QW-1]}});

    always_comb begin
        if (ovf_x) begin
            n_x = qx[QW-1] ? C_MIN : C_MAX;
        end else begin
            n_x = qx[COORD_BITS-1:0];
        end
        if (ovf_y) begin
            n_y = qy[QW-1] ? C_MIN : C_MAX;
        end else begin
            n_y = qy[COORD_BITS-1:0];
        end
    end

    assign o_strobe = r_strobe;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_z      = r_z;
    assign o_sat    = r_sat;

endmodule

// ----- rtl/core/rotate_vector_about_z_unit.sv -----
// a start transfer passes the front registers, the chain of cordic cells and the back registers before the strobe
// throughput: one vector per clock, busy stays low, the receiver cannot stall
// rate is set by the chain of cordic cells, one cell per micro-rotation
// reset: synchronous, active low, clears the valid bits of every stage
// results of vectors in flight at reset are dropped
`timescale 1ns / 1ps

module rotate_vector_about_z_unit import rvz_pkg::*; #(
    parameter int COORD_BITS      = 24,
    parameter int ROTATION_STAGES = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_in_x,
    input  logic signed [COORD_BITS-1:0] i_in_y,
    input  logic signed [COORD_BITS-1:0] i_in_z,
    input  logic signed [YAW_BITS-1:0]   i_yaw_angle,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic signed [COORD_BITS-1:0] o_out_z,
    output logic                         o_saturated
);

    localparam int W   = COORD_BITS + 32;
    localparam int N   = ROTATION_STAGES;
    localparam int LAT = ROTATION_STAGES + 4;

    t_ctrl                        ctl_c   [0:N];
    logic signed [W-1:0]          xs_c    [0:N];
    logic signed [W-1:0]          ys_c    [0:N];
    logic signed [THETA_BITS-1:0] theta_c [0:N];
    logic signed [COORD_BITS-1:0] z_c     [0:N];

    assign busy = 1'b0;

    rvz_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_x      (i_in_x),
        .i_y      (i_in_y),
        .i_z      (i_in_z),
        .i_yaw    (i_yaw_angle),
        .o_ctrl   (ctl_c[0]),
        .o_xs     (xs_c[0]),
        .o_ys     (ys_c[0]),
        .o_theta  (theta_c[0]),
        .o_z      (z_c[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        rvz_cell #(
            .COORD_BITS (COORD_BITS),
            .STAGE      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctl_c[k]),
            .i_xs    (xs_c[k]),
            .i_ys    (ys_c[k]),
            .i_theta (theta_c[k]),
            .i_z     (z_c[k]),
            .o_ctrl  (ctl_c[k+1]),
            .o_xs    (xs_c[k+1]),
            .o_ys    (ys_c[k+1]),
            .o_theta (theta_c[k+1]),
            .o_z     (z_c[k+1])
        );
    end

    rvz_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctl_c[N]),
        .i_xs     (xs_c[N]),
        .i_ys     (ys_c[N]),
        .i_z      (z_c[N]),
        .o_strobe (o_strobe),
        .o_x      (o_out_x),
        .o_y      (o_out_y),
        .o_z      (o_out_z),
        .o_sat    (o_saturated)
    );

    // every accepted vector comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("result strobe missing after a start transfer");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching start transfer");

    a_z_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out_z == $past(i_in_z, LAT)))
        else $error("z coordinate changed on its way through");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |->
            (o_out_x == {1'b0, {(COORD_BITS-1){1'b1}}} ||
             o_out_x == {1'b1, {(COORD_BITS-1){1'b0}}} ||
             o_out_y == {1'b0, {(COORD_BITS-1){1'b1}}} ||
             o_out_y == {1'b1, {(COORD_BITS-1){1'b0}}}))
        else $error("saturation flagged without a clamped coordinate");

endmodule
